@@ src/plfc_pkg.sv @@
// ----------------------------------------------------------------------------
// plfc_pkg
// types and codes shared by the pmbus linear format converter
// ----------------------------------------------------------------------------
package plfc_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int VALUE_WIDTH   = 41;
   localparam int FIXED_WIDTH   = 48;
   localparam int WORD_WIDTH    = 16;
   localparam int EXP_WIDTH     = 5;
   localparam int MANT_WIDTH    = 11;
   localparam int SHIFT_WIDTH   = 5;
   localparam int BITLEN_WIDTH  = 6;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [2:0] OP_DEC_LINEAR11      = 3'd0;
   localparam logic [2:0] OP_ENC_LINEAR11_INT  = 3'd1;
   localparam logic [2:0] OP_ENC_LINEAR11_FRAC = 3'd2;
   localparam logic [2:0] OP_DEC_ULINEAR16     = 3'd3;
   localparam logic [2:0] OP_ENC_ULINEAR16     = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SATURATED = 2'd1;
   localparam logic [1:0] STATUS_ZERO      = 2'd2;

   localparam logic [EXP_WIDTH-1:0] VOUT_EXPONENT_RESET = 5'h17;
   localparam logic [0:0]           REG_VOUT_EXPONENT   = 1'b0;

   localparam logic [MANT_WIDTH-1:0] MANT_MAX = 11'h3FF;
   localparam logic [WORD_WIDTH-1:0] WORD_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]             op;
      logic [VALUE_WIDTH-1:0] value_in;
   } req_data_type;

   typedef struct packed {
      logic signed [FIXED_WIDTH-1:0] fixed_out;
      logic [WORD_WIDTH-1:0]         word_out;
      logic [1:0]                    status;
   } rsp_data_type;

endpackage

@@ src/pmbus_linear_format_converter_unit.sv @@
// ----------------------------------------------------------------------------
// pmbus_linear_format_converter_unit
// converts between linear11 / ulinear16 words and 16-fraction-bit fixed point
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   plfc_pkg::req_data_type
//   rsp       out         rsp_valid / rsp_stall   plfc_pkg::rsp_data_type
//   csr       in          apb write / read        vout_exponent at byte 0
//
// three register stages: leading-one search into the input register, shift
// amount and overflow, shift and format into the result register. a new
// request can enter every cycle unless all stages are full and rsp is
// stalled. each stage holds while the one after it is full and stalled, so
// nothing is dropped or repeated. synchronous reset clears the stage valid
// bits and sets vout_exponent to -9.
// ----------------------------------------------------------------------------
module pmbus_linear_format_converter_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  plfc_pkg::req_data_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output plfc_pkg::rsp_data_type                 rsp_data,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [plfc_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [plfc_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [plfc_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   function automatic logic [plfc_pkg::BITLEN_WIDTH-1:0] bit_length(
      input logic [plfc_pkg::VALUE_WIDTH-1:0] v
   );
      logic [plfc_pkg::BITLEN_WIDTH-1:0] len;
      len = '0;
      for (int i = 0; i < plfc_pkg::VALUE_WIDTH; i++) begin
         if (v[i]) begin
            len = plfc_pkg::BITLEN_WIDTH'(i + 1);
         end
      end
      return len;
   endfunction

   logic [plfc_pkg::EXP_WIDTH-1:0] vout_exponent_ff;
   logic [plfc_pkg::EXP_WIDTH-1:0] vout_exponent_in;

   logic                               s1_valid_ff;
   logic [2:0]                         s1_op_ff;
   logic [plfc_pkg::VALUE_WIDTH-1:0]   s1_value_ff;
   logic [plfc_pkg::BITLEN_WIDTH-1:0]  s1_len_ff;
   logic [plfc_pkg::BITLEN_WIDTH-1:0]  s1_len_in;

   logic                               s2_valid_ff;
   logic [2:0]                         s2_op_ff;
   logic [plfc_pkg::VALUE_WIDTH-1:0]   s2_value_ff;
   logic [plfc_pkg::SHIFT_WIDTH-1:0]   s2_shift_ff;
   logic                               s2_ovf_ff;
   logic [plfc_pkg::SHIFT_WIDTH-1:0]   s2_shift_in;
   logic                               s2_ovf_in;

   logic                               rsp_valid_ff;
   plfc_pkg::rsp_data_type             rsp_data_ff;
   plfc_pkg::rsp_data_type             rsp_data_in;

   logic s1_ready, s2_ready, s3_ready;
   logic csr_write;

   logic [plfc_pkg::BITLEN_WIDTH-1:0]  s1_len_m10;
   logic [plfc_pkg::SHIFT_WIDTH-1:0]   vout_shift;

   logic [plfc_pkg::VALUE_WIDTH-1:0]   s2_rshift;
   logic [plfc_pkg::FIXED_WIDTH-1:0]   s2_mant_ext;
   logic [plfc_pkg::FIXED_WIDTH-1:0]   s2_word_ext;

   // handshake chain
   assign s3_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == plfc_pkg::REG_VOUT_EXPONENT);
   assign csr_prdata = (csr_paddr[2] == plfc_pkg::REG_VOUT_EXPONENT) ?
                       {{(plfc_pkg::CSR_DATA_WIDTH - plfc_pkg::EXP_WIDTH){1'b0}},
                        vout_exponent_ff} : '0;

   always_comb begin
      vout_exponent_in = vout_exponent_ff;
      if (csr_write) begin
         vout_exponent_in = csr_pwdata[plfc_pkg::EXP_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_exponent_ff <= plfc_pkg::VOUT_EXPONENT_RESET;
      end else begin
         vout_exponent_ff <= vout_exponent_in;
      end
   end

   // stage 1: capture and leading one
   assign s1_len_in = bit_length(req_data.value_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_op_ff    <= req_data.op;
         s1_value_ff <= req_data.value_in;
         s1_len_ff   <= s1_len_in;
      end
   end

   // stage 2: shift amount
   assign s1_len_m10 = s1_len_ff - plfc_pkg::BITLEN_WIDTH'(10);
   // exponent + fraction bits, modulo 32
   assign vout_shift = {~vout_exponent_ff[4], vout_exponent_ff[3:0]};

   always_comb begin
      s2_shift_in = '0;
      s2_ovf_in   = 1'b0;
      case (s1_op_ff)
         plfc_pkg::OP_DEC_LINEAR11: begin
            s2_shift_in = {~s1_value_ff[15], s1_value_ff[14:11]};
         end
         plfc_pkg::OP_ENC_LINEAR11_INT: begin
            if (s1_len_ff > plfc_pkg::BITLEN_WIDTH'(26)) begin
               s2_shift_in = s1_len_m10[plfc_pkg::SHIFT_WIDTH-1:0];
            end else begin
               s2_shift_in = plfc_pkg::SHIFT_WIDTH'(plfc_pkg::FRACTION_BITS);
            end
         end
         plfc_pkg::OP_ENC_LINEAR11_FRAC: begin
            if (s1_len_ff > plfc_pkg::BITLEN_WIDTH'(11)) begin
               s2_shift_in = s1_len_m10[plfc_pkg::SHIFT_WIDTH-1:0];
            end else begin
               s2_shift_in = plfc_pkg::SHIFT_WIDTH'(1);
            end
            s2_ovf_in = (s1_len_ff > plfc_pkg::BITLEN_WIDTH'(27));
         end
         plfc_pkg::OP_DEC_ULINEAR16: begin
            s2_shift_in = vout_shift;
         end
         plfc_pkg::OP_ENC_ULINEAR16: begin
            s2_shift_in = vout_shift;
         end
         default: begin
            s2_shift_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_op_ff    <= s1_op_ff;
         s2_value_ff <= s1_value_ff;
         s2_shift_ff <= s2_shift_in;
         s2_ovf_ff   <= s2_ovf_in;
      end
   end

   // stage 3: shift and format
   assign s2_rshift   = s2_value_ff >> s2_shift_ff;
   assign s2_mant_ext = {{(plfc_pkg::FIXED_WIDTH - plfc_pkg::MANT_WIDTH){s2_value_ff[10]}},
                         s2_value_ff[10:0]};
   assign s2_word_ext = {{(plfc_pkg::FIXED_WIDTH - plfc_pkg::WORD_WIDTH){1'b0}},
                         s2_value_ff[15:0]};

   always_comb begin
      rsp_data_in = '0;
      case (s2_op_ff)
         plfc_pkg::OP_DEC_LINEAR11: begin
            rsp_data_in.fixed_out = s2_mant_ext << s2_shift_ff;
         end
         plfc_pkg::OP_ENC_LINEAR11_INT: begin
            rsp_data_in.word_out = {1'b0, s2_shift_ff[3:0], s2_rshift[10:0]};
         end
         plfc_pkg::OP_ENC_LINEAR11_FRAC: begin
            if (s2_value_ff == '0) begin
               rsp_data_in.status = plfc_pkg::STATUS_ZERO;
            end else if (s2_ovf_ff) begin
               rsp_data_in.word_out = {5'd1, plfc_pkg::MANT_MAX};
               rsp_data_in.status   = plfc_pkg::STATUS_SATURATED;
            end else begin
               rsp_data_in.word_out = {~s2_shift_ff[4], s2_shift_ff[3:0], s2_rshift[10:0]};
            end
         end
         plfc_pkg::OP_DEC_ULINEAR16: begin
            rsp_data_in.fixed_out = s2_word_ext << s2_shift_ff;
         end
         plfc_pkg::OP_ENC_ULINEAR16: begin
            if (s2_rshift[plfc_pkg::VALUE_WIDTH-1:plfc_pkg::WORD_WIDTH] != '0) begin
               rsp_data_in.word_out = plfc_pkg::WORD_MAX;
               rsp_data_in.status   = plfc_pkg::STATUS_SATURATED;
            end else begin
               rsp_data_in.word_out = s2_rshift[plfc_pkg::WORD_WIDTH-1:0];
            end
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while pipeline has room");

   a_zero_gives_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == plfc_pkg::STATUS_ZERO) |->
      (rsp_data.word_out == '0 && rsp_data.fixed_out == '0))
      else $error("zero-input status with nonzero result");

   a_saturation_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == plfc_pkg::STATUS_SATURATED) |->
      (rsp_data.word_out == plfc_pkg::WORD_MAX ||
       rsp_data.word_out[10:0] == plfc_pkg::MANT_MAX))
      else $error("saturated status without saturated word");
`endif

endmodule

@@ dv/tb_pmbus_linear_format_converter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pmbus_linear_format_converter_unit
// self-checking bench for the pmbus linear11 / ulinear16 format converter
//
// a driver pushes requests from a pending queue onto the req channel, and each
// accepted request is converted by a local model of the five conversions. The
// predicted results wait in order. A monitor pops them and compares every
// field of each accepted rsp. Phases change vout_exponent over the apb port
// and read it back, including both extremes. The phases also rotate the
// sender idle and receiver stall patterns. The directed requests cover the
// field extremes, zero and tiny fractions, saturation and the undefined ops.
// ----------------------------------------------------------------------------
module tb_pmbus_linear_format_converter_unit;

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 85;
   localparam int DRAIN_CYCLES  = 8;
   localparam int TIMEOUT_NS    = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   plfc_pkg::req_data_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   plfc_pkg::rsp_data_type rsp_data;

   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [plfc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [plfc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [plfc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                csr_pready;

   plfc_pkg::req_data_type pending_requests[$];
   plfc_pkg::rsp_data_type predicted_results[$];
   plfc_pkg::rsp_data_type expected_rsp;

   logic signed [plfc_pkg::EXP_WIDTH-1:0] vout_exponent_model =
      plfc_pkg::VOUT_EXPONENT_RESET;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;

   pmbus_linear_format_converter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // sign and magnitude scaled by 2^sh into 48-bit two's complement, saturating
   function automatic logic [plfc_pkg::FIXED_WIDTH-1:0] to_fixed_point(
      logic [63:0] mag, logic neg, int sh, inout logic [1:0] st);
      logic [63:0] limit;
      logic [63:0] m;
      limit = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      if (sh >= 0) begin
         if (mag != 0 && (sh >= plfc_pkg::FIXED_WIDTH || mag > (limit >> sh))) begin
            m = limit;
            st = plfc_pkg::STATUS_SATURATED;
         end else begin
            m = mag << sh;
         end
      end else begin
         m = (-sh >= 64) ? 64'd0 : mag >> (-sh);
      end
      return neg ? plfc_pkg::FIXED_WIDTH'(64'd0 - m) : m[plfc_pkg::FIXED_WIDTH-1:0];
   endfunction

   function automatic plfc_pkg::rsp_data_type predict_conversion(
      plfc_pkg::req_data_type r, logic signed [plfc_pkg::EXP_WIDTH-1:0] vexp);
      plfc_pkg::rsp_data_type res;
      logic [plfc_pkg::WORD_WIDTH-1:0] w;
      logic [63:0] v;
      logic [63:0] m;
      logic [63:0] mag;
      logic [1:0] st;
      logic found;
      int e;
      int k;
      res = '0;
      st = plfc_pkg::STATUS_OK;
      v = 64'(r.value_in);
      w = r.value_in[plfc_pkg::WORD_WIDTH-1:0];
      m = '0;
      e = 0;
      found = 1'b0;
      case (r.op)
         plfc_pkg::OP_DEC_LINEAR11: begin
            e = $signed(w[15:11]);
            mag = w[10] ? 64'd2048 - 64'(w[10:0]) : 64'(w[10:0]);
            res.fixed_out = to_fixed_point(mag, w[10], e + plfc_pkg::FRACTION_BITS, st);
         end
         plfc_pkg::OP_ENC_LINEAR11_INT: begin
            for (k = 0; k <= 15 && !found; k++) begin
               if (((v >> plfc_pkg::FRACTION_BITS) >> k) <= 64'(plfc_pkg::MANT_MAX)) begin
                  found = 1'b1;
                  e = k;
                  m = (v >> plfc_pkg::FRACTION_BITS) >> k;
               end
            end
            if (!found) begin
               e = 15;
               m = 64'(plfc_pkg::MANT_MAX);
               st = plfc_pkg::STATUS_SATURATED;
            end
            res.word_out = {5'(e), m[10:0]};
         end
         plfc_pkg::OP_ENC_LINEAR11_FRAC: begin
            if (v == 0) begin
               st = plfc_pkg::STATUS_ZERO;
            end else begin
               // k counts fraction bits, from 15 down to -1
               for (k = 15; k >= -1 && !found; k--) begin
                  if ((v >> (plfc_pkg::FRACTION_BITS - k)) <= 64'(plfc_pkg::MANT_MAX)) begin
                     found = 1'b1;
                     e = k;
                     m = v >> (plfc_pkg::FRACTION_BITS - k);
                  end
               end
               if (!found) begin
                  e = -1;
                  m = 64'(plfc_pkg::MANT_MAX);
                  st = plfc_pkg::STATUS_SATURATED;
               end
               res.word_out = {5'(32 - e), m[10:0]};
            end
         end
         plfc_pkg::OP_DEC_ULINEAR16: begin
            res.fixed_out = to_fixed_point(64'(w), 1'b0,
                                           int'(vexp) + plfc_pkg::FRACTION_BITS, st);
         end
         plfc_pkg::OP_ENC_ULINEAR16: begin
            m = v >> (int'(vexp) + plfc_pkg::FRACTION_BITS);
            if (m > 64'(plfc_pkg::WORD_MAX)) begin
               m = 64'(plfc_pkg::WORD_MAX);
               st = plfc_pkg::STATUS_SATURATED;
            end
            res.word_out = m[plfc_pkg::WORD_WIDTH-1:0];
         end
         default: begin
         end
      endcase
      res.status = st;
      return res;
   endfunction

   function automatic logic [plfc_pkg::VALUE_WIDTH-1:0] random_value();
      logic [63:0] raw;
      int len;
      raw = {$urandom, $urandom};
      len = $urandom_range(plfc_pkg::VALUE_WIDTH);
      case ($urandom_range(3))
         0: return raw[plfc_pkg::VALUE_WIDTH-1:0];
         1: return raw[plfc_pkg::VALUE_WIDTH-1:0] &
                   ((plfc_pkg::VALUE_WIDTH'(1) << len) - plfc_pkg::VALUE_WIDTH'(1));
         2: return plfc_pkg::VALUE_WIDTH'(64'($urandom_range(2047)) << $urandom_range(30));
         default: return (plfc_pkg::VALUE_WIDTH'(1) << len) -
                         plfc_pkg::VALUE_WIDTH'($urandom_range(1));
      endcase
   endfunction

   task automatic add_request(logic [2:0] op, logic [plfc_pkg::VALUE_WIDTH-1:0] value);
      plfc_pkg::req_data_type r;
      r.op = op;
      r.value_in = value;
      pending_requests.push_back(r);
   endtask

   task automatic add_random_requests(int count);
      logic [2:0] op;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0) begin
            op = 3'($urandom_range(7, 5));
         end else begin
            op = 3'($urandom_range(4));
         end
         add_request(op, random_value());
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || predicted_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic csr_access(logic write, logic [plfc_pkg::CSR_DATA_WIDTH-1:0] wdata,
                             output logic [plfc_pkg::CSR_DATA_WIDTH-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {plfc_pkg::REG_VOUT_EXPONENT, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_vout_exponent(logic signed [plfc_pkg::EXP_WIDTH-1:0] vexp);
      logic [plfc_pkg::CSR_DATA_WIDTH-1:0] rdata;
      csr_access(1'b1, plfc_pkg::CSR_DATA_WIDTH'(vexp), rdata);
      vout_exponent_model = vexp;
      csr_access(1'b0, '0, rdata);
      if (rdata[plfc_pkg::EXP_WIDTH-1:0] !== vexp) begin
         $error("vout_exponent mismatch: expected %0d, got %0d", vexp,
                $signed(rdata[plfc_pkg::EXP_WIDTH-1:0]));
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_results.push_back(predict_conversion(req_data, vout_exponent_model));
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $error("rsp with no request outstanding");
               error_count++;
            end else begin
               expected_rsp = predicted_results.pop_front();
               if (rsp_data.fixed_out !== expected_rsp.fixed_out) begin
                  $error("fixed_out mismatch: expected %0d, got %0d",
                         expected_rsp.fixed_out, rsp_data.fixed_out);
                  error_count++;
               end
               if (rsp_data.word_out !== expected_rsp.word_out) begin
                  $error("word_out mismatch: expected %h, got %h",
                         expected_rsp.word_out, rsp_data.word_out);
                  error_count++;
               end
               if (rsp_data.status !== expected_rsp.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         expected_rsp.status, rsp_data.status);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      int phase_exp[PHASES];
      phase_exp = '{-16, 15, 0, 1, -1, 0, 7, -9};
      phase_exp[5] = $urandom_range(31) - 16;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset exponent
      add_request(plfc_pkg::OP_DEC_LINEAR11, 41'h0000);
      add_request(plfc_pkg::OP_DEC_LINEAR11, 41'h7BFF);
      add_request(plfc_pkg::OP_DEC_LINEAR11, 41'h8400);
      add_request(plfc_pkg::OP_DEC_LINEAR11, 41'h7C00);
      add_request(plfc_pkg::OP_DEC_LINEAR11, 41'h1FF_FFFF_FFFF);
      add_request(plfc_pkg::OP_ENC_LINEAR11_INT, 41'h0);
      add_request(plfc_pkg::OP_ENC_LINEAR11_INT, 41'h0_FFFF);
      add_request(plfc_pkg::OP_ENC_LINEAR11_INT, 41'h3FF_FFFF);
      add_request(plfc_pkg::OP_ENC_LINEAR11_INT, 41'h400_0000);
      add_request(plfc_pkg::OP_ENC_LINEAR11_INT, 41'h1FF_FFFF_FFFF);
      add_request(plfc_pkg::OP_ENC_LINEAR11_FRAC, 41'h0);
      add_request(plfc_pkg::OP_ENC_LINEAR11_FRAC, 41'h1);
      add_request(plfc_pkg::OP_ENC_LINEAR11_FRAC, 41'h1_0000);
      add_request(plfc_pkg::OP_ENC_LINEAR11_FRAC, 41'h7FE_0000);
      add_request(plfc_pkg::OP_ENC_LINEAR11_FRAC, 41'h800_0000);
      add_request(plfc_pkg::OP_ENC_LINEAR11_FRAC, 41'h1FF_FFFF_FFFF);
      add_request(plfc_pkg::OP_DEC_ULINEAR16, 41'h0);
      add_request(plfc_pkg::OP_DEC_ULINEAR16, 41'h1FF_FFFF_FFFF);
      add_request(plfc_pkg::OP_ENC_ULINEAR16, 41'h0);
      add_request(plfc_pkg::OP_ENC_ULINEAR16, 41'h7F_FF80);
      add_request(plfc_pkg::OP_ENC_ULINEAR16, 41'h1FF_FFFF_FFFF);
      add_request(3'd5, 41'h1FF_FFFF_FFFF);
      add_request(3'd6, 41'h155_5555_5555);
      add_request(3'd7, 41'h0AA_AAAA_AAAA);
      wait_for_drain();

      for (int p = 0; p < PHASES; p++) begin
         set_vout_exponent(plfc_pkg::EXP_WIDTH'(phase_exp[p]));
         @(negedge clock);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 70;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 70;
            end
            default: begin
               send_idle_pct = 6;
               stall_pct = 6;
            end
         endcase
         add_random_requests(PHASE_ITEMS);
         wait_for_drain();
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ pmbus_linear_format_converter_unit.f @@
src/plfc_pkg.sv
src/pmbus_linear_format_converter_unit.sv
dv/tb_pmbus_linear_format_converter_unit.sv
